// ----- rtl/core/assert_macros.svh -----
// Assertion macros included by work_stealing_deque.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/core/wsd_pkg.sv -----
package wsd_pkg;

    // Ring size and task handle width
    localparam int DEPTH     = 1024;
    localparam int ITEM_BITS = 32;

    // Derived widths: slot address, index (counts modulo 2*DEPTH), occupancy
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(2 * DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);

    typedef logic [1:0]           t_op;
    typedef logic [1:0]           t_status;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [OCC_W-1:0]     t_occ;
    typedef logic [ITEM_BITS-1:0] t_item;

    // Operation codes
    localparam t_op OP_PUSH       = 2'd0;
    localparam t_op OP_POP_BOTTOM = 2'd1;
    localparam t_op OP_STEAL      = 2'd2;

    // Status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam t_idx IDX_LAST  = t_idx'(2 * DEPTH - 1);
    localparam t_idx IDX_DEPTH = t_idx'(DEPTH);

    // Index step forward, wrapping at 2*DEPTH
    function automatic t_idx idx_inc(input t_idx i);
        return (i == IDX_LAST) ? '0 : t_idx'(i + 1'b1);
    endfunction

    // Index step back, wrapping at 2*DEPTH
    function automatic t_idx idx_dec(input t_idx i);
        return (i == '0) ? IDX_LAST : t_idx'(i - 1'b1);
    endfunction

    // Memory slot of an index
    function automatic logic [ADDR_W-1:0] slot_of(input t_idx i);
        t_idx s;
        s = (i >= IDX_DEPTH) ? t_idx'(i - IDX_DEPTH) : i;
        return s[ADDR_W-1:0];
    endfunction

    // Entries held between top and bottom
    function automatic t_occ count_held(input t_idx t, input t_idx b);
        t_idx d;
        d = (b >= t) ? t_idx'(b - t) : t_idx'(b + IDX_LAST + 1'b1 - t);
        return d[OCC_W-1:0];
    endfunction

endpackage

// ----- rtl/core/wsd_op_if.sv -----
// Operation channel: one deque operation per transfer
interface wsd_op_if;
    logic             valid;
    logic             ready;
    wsd_pkg::t_op     op;
    wsd_pkg::t_item   item_in;

    modport source (output valid, output op, output item_in, input ready);
    modport sink   (input valid, input op, input item_in, output ready);
endinterface

// ----- rtl/core/wsd_res_if.sv -----
// Result channel: one result per operation
interface wsd_res_if;
    logic              valid;
    logic              ready;
    wsd_pkg::t_item    item_out;
    wsd_pkg::t_status  status;
    wsd_pkg::t_occ     occupancy;

    modport source (output valid, output item_out, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input item_out, input status, input occupancy,
                    output ready);
endinterface

// ----- rtl/core/wsd_ram.sv -----
// Single port write, single port read RAM with registered read data
module wsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/work_stealing_deque.sv -----
// Work-stealing deque of task handles held in a ring memory.
// i_op_ch carries one operation per transfer: push at bottom, pop at bottom
// (owner) or pop at top (steal), with the handle to push. o_res_ch returns
// exactly one result per operation, in order: the handle taken (zero when
// none), a status (ok, empty, full) and the entries held afterwards.
// For pushes, empty pops, full pushes and the unused code the result is
// registered at the transfer edge and shows in the next cycle. A pop that
// takes an entry needs the registered read of the ring memory, so it passes
// through S_READ, where the operation channel drops ready; pushes run at one
// per cycle while results are taken, a taking pop holds the next op back.
// The indexes are updated at the transfer edge, so the next operation
// always sees them current; a read never overlaps a write to its entry.
// Reset (synchronous, active low) empties the deque by clearing both
// indexes; ring contents are not cleared and need no clearing pass.
// When the result receiver stalls, the result waits in the output register
// and no new operation is taken until it has been transferred.
`include "assert_macros.svh"

module work_stealing_deque (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsd_op_if.sink     i_op_ch,
    wsd_res_if.source  o_res_ch
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state                    r_state, n_state;
    wsd_pkg::t_idx             r_top, n_top;
    wsd_pkg::t_idx             r_bot, n_bot;
    logic                      r_out_valid, n_out_valid;
    wsd_pkg::t_item            r_item_out, n_item_out;
    wsd_pkg::t_status          r_status, n_status;
    wsd_pkg::t_occ             r_occ, n_occ;

    logic                      w_in_ready;
    logic                      w_acc;
    wsd_pkg::t_occ             w_held;
    logic                      w_empty;
    logic                      w_full;
    logic                      w_push_ok;
    logic                      w_pop_ok;
    wsd_pkg::t_idx             w_bot_m1;
    logic [wsd_pkg::ADDR_W-1:0] w_raddr;
    wsd_pkg::t_item            w_rdata;

    // Occupancy and handshake
    assign w_held     = wsd_pkg::count_held(r_top, r_bot);
    assign w_empty    = (w_held == '0);
    assign w_full     = (w_held == wsd_pkg::t_occ'(wsd_pkg::DEPTH));
    assign w_in_ready = (r_state == S_IDLE) && (!r_out_valid || o_res_ch.ready);
    assign w_acc      = i_op_ch.valid && w_in_ready;
    assign w_push_ok  = (i_op_ch.op == wsd_pkg::OP_PUSH) && !w_full;
    assign w_pop_ok   = ((i_op_ch.op == wsd_pkg::OP_POP_BOTTOM) ||
                         (i_op_ch.op == wsd_pkg::OP_STEAL)) && !w_empty;
    assign w_bot_m1   = wsd_pkg::idx_dec(r_bot);

    // Read the bottom entry for an owner pop, the top entry for a steal
    assign w_raddr = (i_op_ch.op == wsd_pkg::OP_POP_BOTTOM) ?
                     wsd_pkg::slot_of(w_bot_m1) : wsd_pkg::slot_of(r_top);

    wsd_ram #(
        .WIDTH (wsd_pkg::ITEM_BITS),
        .DEPTH (wsd_pkg::DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_acc && w_push_ok),
        .i_waddr (wsd_pkg::slot_of(r_bot)),
        .i_wdata (i_op_ch.item_in),
        .i_re    (w_acc && w_pop_ok),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Index update and result formation
    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_bot       = r_bot;
        n_out_valid = r_out_valid;
        n_item_out  = r_item_out;
        n_status    = r_status;
        n_occ       = r_occ;

        if (r_out_valid && o_res_ch.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_item_out = '0;
                    n_status   = wsd_pkg::ST_OK;
                    n_occ      = w_held;
                    if (i_op_ch.op == wsd_pkg::OP_PUSH) begin
                        if (w_full) begin
                            n_status = wsd_pkg::ST_FULL;
                        end else begin
                            n_bot = wsd_pkg::idx_inc(r_bot);
                            n_occ = wsd_pkg::t_occ'(w_held + 1'b1);
                        end
                    end else if (w_pop_ok) begin
                        n_occ = wsd_pkg::t_occ'(w_held - 1'b1);
                        if (i_op_ch.op == wsd_pkg::OP_STEAL) begin
                            n_top = wsd_pkg::idx_inc(r_top);
                        end else if (w_held == wsd_pkg::t_occ'(1)) begin
                            // last entry: both indexes move past it
                            n_top = wsd_pkg::idx_inc(r_top);
                            n_bot = wsd_pkg::idx_inc(r_top);
                        end else begin
                            n_bot = w_bot_m1;
                        end
                    end else if ((i_op_ch.op == wsd_pkg::OP_POP_BOTTOM) ||
                                 (i_op_ch.op == wsd_pkg::OP_STEAL)) begin
                        n_status = wsd_pkg::ST_EMPTY;
                    end
                    // a taking pop waits in S_READ for the ring read data
                    if (w_pop_ok) begin
                        n_state     = S_READ;
                        n_out_valid = 1'b0;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_item_out  = w_rdata;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_bot       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_bot       <= n_bot;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_item_out <= n_item_out;
        r_status   <= n_status;
        r_occ      <= n_occ;
    end

    assign i_op_ch.ready      = w_in_ready;
    assign o_res_ch.valid     = r_out_valid;
    assign o_res_ch.item_out  = r_item_out;
    assign o_res_ch.status    = r_status;
    assign o_res_ch.occupancy = r_occ;

    // Checks
    `ASSERT_NEVER(a_occ_range, i_clk, i_rst_n, w_held > wsd_pkg::t_occ'(wsd_pkg::DEPTH), "occupancy beyond depth")
    `ASSERT_CLK(a_read_slot_free, i_clk, i_rst_n, (r_state == S_READ) |-> !r_out_valid, "read data would overwrite a pending result")
    `ASSERT_CLK(a_push_grows, i_clk, i_rst_n, (w_acc && w_push_ok) |=> (w_held == wsd_pkg::t_occ'($past(w_held) + 1'b1)), "push did not add an entry")
    `ASSERT_CLK(a_pop_result_next, i_clk, i_rst_n, (w_acc && w_pop_ok) |=> ((r_state == S_READ) ##1 r_out_valid), "taking pop result not delivered after read")
    `ASSERT_CLK(a_occ_reported, i_clk, i_rst_n, $rose(r_out_valid) |-> (r_occ == w_held), "reported occupancy differs from indexes")

endmodule

// ----- sim/work_stealing_deque_test.sv -----
`timescale 1ns / 100ps

module work_stealing_deque_test;

    // Spare operation code: the block answers it without touching the deque
    localparam wsd_pkg::t_op OP_UNUSED = 2'd3;

    typedef struct packed {
        wsd_pkg::t_item   item;
        wsd_pkg::t_status status;
        wsd_pkg::t_occ    occ;
    } t_deque_result;

    typedef struct packed {
        wsd_pkg::t_op   op;
        wsd_pkg::t_item item;
        bit             typed;
        t_deque_result  want;
    } t_deque_row;

    logic i_clk;
    logic i_rst_n;

    wsd_op_if  op_ch ();
    wsd_res_if res_ch ();

    work_stealing_deque dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op_ch  (op_ch),
        .o_res_ch (res_ch)
    );

    // Shadow deque: ring contents and both indexes
    wsd_pkg::t_item deque_slots [wsd_pkg::DEPTH];
    wsd_pkg::t_idx  head_idx = '0;
    wsd_pkg::t_idx  tail_idx = '0;

    t_deque_result awaited_results [$];
    int            mismatch_count = 0;
    bit            steady = 1'b0;      // no idling on either side while set
    t_deque_row    directed_ops [16];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("work_stealing_deque verification failed");
        $finish;
    end

    // Indexes count modulo twice the ring size
    function automatic wsd_pkg::t_idx idx_after(input wsd_pkg::t_idx i);
        return wsd_pkg::t_idx'((int'(i) + 1) % (2 * wsd_pkg::DEPTH));
    endfunction

    function automatic wsd_pkg::t_idx idx_before(input wsd_pkg::t_idx i);
        return wsd_pkg::t_idx'((int'(i) + 2 * wsd_pkg::DEPTH - 1) % (2 * wsd_pkg::DEPTH));
    endfunction

    function automatic int held_now();
        return (int'(tail_idx) - int'(head_idx) + 2 * wsd_pkg::DEPTH) % (2 * wsd_pkg::DEPTH);
    endfunction

    // Apply one operation to the shadow deque and return its result
    function automatic t_deque_result predict_deque_op(input wsd_pkg::t_op op,
                                                       input wsd_pkg::t_item item);
        t_deque_result r;
        wsd_pkg::t_idx newest;
        int            held;
        r    = '0;
        held = held_now();
        case (op)
            wsd_pkg::OP_PUSH: begin
                if (held == wsd_pkg::DEPTH) begin
                    r.status = wsd_pkg::ST_FULL;
                end else begin
                    deque_slots[int'(tail_idx) % wsd_pkg::DEPTH] = item;
                    tail_idx = idx_after(tail_idx);
                end
            end
            wsd_pkg::OP_POP_BOTTOM: begin
                if (held == 0) begin
                    r.status = wsd_pkg::ST_EMPTY;
                end else begin
                    newest = idx_before(tail_idx);
                    r.item = deque_slots[int'(newest) % wsd_pkg::DEPTH];
                    // last entry: both indexes step past it
                    if (held == 1) begin
                        head_idx = idx_after(head_idx);
                        tail_idx = head_idx;
                    end else begin
                        tail_idx = newest;
                    end
                end
            end
            wsd_pkg::OP_STEAL: begin
                if (held == 0) begin
                    r.status = wsd_pkg::ST_EMPTY;
                end else begin
                    r.item   = deque_slots[int'(head_idx) % wsd_pkg::DEPTH];
                    head_idx = idx_after(head_idx);
                end
            end
            default: ;
        endcase
        r.occ = wsd_pkg::t_occ'(held_now());
        return r;
    endfunction

    function automatic wsd_pkg::t_op pick_op(input int push_pct, input int steal_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return wsd_pkg::OP_PUSH;
        if (r < push_pct + steal_pct)
            return wsd_pkg::OP_STEAL;
        if (r < 97)
            return wsd_pkg::OP_POP_BOTTOM;
        return OP_UNUSED;
    endfunction

    // Present one operation, wait for its transfer, then log what should come back.
    // Entered and left at a falling edge; valid stays high between back-to-back ops.
    task automatic issue_op(input wsd_pkg::t_op op, input wsd_pkg::t_item item,
                            input bit typed, input t_deque_result want);
        t_deque_result predicted;
        while (!steady && $urandom_range(0, 99) < 19) begin
            op_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        op_ch.valid   = 1'b1;
        op_ch.op      = op;
        op_ch.item_in = item;
        do @(posedge i_clk); while (op_ch.ready !== 1'b1);
        predicted = predict_deque_op(op, item);
        awaited_results.insert(awaited_results.size(), typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic issue_random(input wsd_pkg::t_op op);
        issue_op(op, $urandom, 1'b0, '0);
    endtask

    // Result receiver back-pressure
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready = steady || ($urandom_range(0, 99) >= 19);
        end
    end

    // Compare every result transfer with the oldest outstanding expected result
    always @(posedge i_clk) begin : check_results
        t_deque_result want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                $error("result transfer with no operation outstanding");
                mismatch_count++;
            end else begin
                want = awaited_results[0];
                awaited_results.delete(0);
                if (res_ch.item_out !== want.item) begin
                    $error("item_out: expected %h, got %h", want.item, res_ch.item_out);
                    mismatch_count++;
                end
                if (res_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_ch.status);
                    mismatch_count++;
                end
                if (res_ch.occupancy !== want.occ) begin
                    $error("occupancy: expected %0d, got %0d", want.occ, res_ch.occupancy);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        op_ch.valid   = 1'b0;
        op_ch.op      = wsd_pkg::OP_PUSH;
        op_ch.item_in = '0;

        // Directed sequence; typed rows carry their answer, the rest are predicted
        directed_ops = '{
            '{wsd_pkg::OP_STEAL,      32'h0000_0000, 1'b1,
              '{32'h0,         wsd_pkg::ST_EMPTY, wsd_pkg::t_occ'(0)}},
            '{wsd_pkg::OP_POP_BOTTOM, 32'hFFFF_FFFF, 1'b1,
              '{32'h0,         wsd_pkg::ST_EMPTY, wsd_pkg::t_occ'(0)}},
            '{OP_UNUSED,              32'h1234_5678, 1'b1,
              '{32'h0,         wsd_pkg::ST_OK,    wsd_pkg::t_occ'(0)}},
            '{wsd_pkg::OP_PUSH,       32'hFFFF_FFFF, 1'b1,
              '{32'h0,         wsd_pkg::ST_OK,    wsd_pkg::t_occ'(1)}},
            '{wsd_pkg::OP_POP_BOTTOM, 32'h0000_0000, 1'b1,
              '{32'hFFFF_FFFF, wsd_pkg::ST_OK,    wsd_pkg::t_occ'(0)}},
            '{wsd_pkg::OP_STEAL,      32'h0000_0000, 1'b1,
              '{32'h0,         wsd_pkg::ST_EMPTY, wsd_pkg::t_occ'(0)}},
            '{wsd_pkg::OP_PUSH,       32'h0000_0000, 1'b1,
              '{32'h0,         wsd_pkg::ST_OK,    wsd_pkg::t_occ'(1)}},
            '{wsd_pkg::OP_PUSH,       32'h8000_0000, 1'b1,
              '{32'h0,         wsd_pkg::ST_OK,    wsd_pkg::t_occ'(2)}},
            '{wsd_pkg::OP_PUSH,       32'h0000_0001, 1'b0, '0},
            '{OP_UNUSED,              32'hFFFF_FFFF, 1'b0, '0},
            '{wsd_pkg::OP_STEAL,      32'hDEAD_0000, 1'b0, '0},
            '{wsd_pkg::OP_PUSH,       32'h5A5A_5A5A, 1'b0, '0},
            '{wsd_pkg::OP_POP_BOTTOM, 32'h0000_0000, 1'b0, '0},
            '{wsd_pkg::OP_STEAL,      32'h0000_0000, 1'b0, '0},
            '{wsd_pkg::OP_STEAL,      32'h0000_0000, 1'b0, '0},
            '{wsd_pkg::OP_POP_BOTTOM, 32'h0000_0000, 1'b1,
              '{32'h0,         wsd_pkg::ST_EMPTY, wsd_pkg::t_occ'(0)}}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_ops[i])
            issue_op(directed_ops[i].op, directed_ops[i].item, directed_ops[i].typed,
                     directed_ops[i].want);

        // Mixed traffic, the first stretch without idling
        steady = 1'b1;
        for (int n = 0; n < 200; n++) begin
            if (n == 100)
                steady = 1'b0;
            issue_random(pick_op(50, 23));
        end

        // Build up a backlog, then drain it mostly by steals down to empty pops
        for (int n = 0; n < 100; n++)
            issue_random(pick_op(75, 10));
        issue_random(OP_UNUSED);
        for (int n = 0; n < 130; n++)
            issue_random(pick_op(10, 50));

        op_ch.valid = 1'b0;

        // Let outstanding results drain, then settle
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("work_stealing_deque verification clean");
        else
            $display("work_stealing_deque verification failed");
        $finish;
    end

endmodule

// ----- work_stealing_deque.f -----
+incdir+rtl/core
rtl/core/wsd_pkg.sv
rtl/core/wsd_op_if.sv
rtl/core/wsd_res_if.sv
rtl/core/wsd_ram.sv
rtl/core/work_stealing_deque.sv
sim/work_stealing_deque_test.sv
